/* sv/dsft_pkg.sv */
// shared types, constants and frame builder for the four-channel dshot transmitter
package dsft_pkg;

  // fixed geometry
  localparam int MOTOR_COUNT = 4;
  localparam int SLOT_W      = 5;
  localparam int COUNT_W     = 16;
  localparam int VALUE_W     = 11;
  localparam int FRAME_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEMETRY  = 3'd4;

  // register reset values
  localparam logic [7:0]         PRESCALE_RST   = 8'd7;
  localparam logic [COUNT_W-1:0] BIT_PERIOD_RST = 16'd34;
  localparam logic [COUNT_W-1:0] ONE_HIGH_RST   = 16'd26;
  localparam logic [COUNT_W-1:0] ZERO_HIGH_RST  = 16'd13;

  // input word
  typedef struct packed {
    logic               req_type;
    logic [VALUE_W-1:0] motor_value_1;
    logic [VALUE_W-1:0] motor_value_2;
    logic [VALUE_W-1:0] motor_value_3;
    logic [VALUE_W-1:0] motor_value_4;
  } in_word_t;

  // result word
  typedef struct packed {
    logic pin_1;
    logic pin_2;
    logic pin_3;
    logic pin_4;
    logic busy_res;
  } out_word_t;

  // timebase position shared by all lanes
  typedef struct packed {
    logic               sending;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } tb_state_t;

  // value, telemetry bit, then xor of the three nibbles
  function automatic logic [FRAME_W-1:0] build_frame(input logic [VALUE_W-1:0] value,
                                                     input logic telem);
    logic [11:0] word;
    logic [3:0]  csum;
    word = {value, telem};
    csum = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, csum};
  endfunction

endpackage

/* sv/dsft_timebase.sv */
// shared prescaler, bit period counter and slot counter
module dsft_timebase #(
  parameter int FRAME_SLOTS = 18
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       tick,
  input  logic [7:0]                 prescale,
  input  logic [dsft_pkg::COUNT_W-1:0] bit_period,
  output dsft_pkg::tb_state_t        state_nxt
);
  import dsft_pkg::*;

  localparam logic [SLOT_W:0] SLOT_END = (SLOT_W+1)'(FRAME_SLOTS);

  logic [7:0]         pre_cnt_r, pre_cnt_nxt;
  logic [COUNT_W-1:0] per_cnt_r, per_cnt_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               sending_r, sending_nxt;
  logic [SLOT_W:0]    slot_inc;

  assign slot_inc = {1'b0, slot_r} + {{SLOT_W{1'b0}}, 1'b1};

  // next timebase position
  always_comb begin
    pre_cnt_nxt = pre_cnt_r;
    per_cnt_nxt = per_cnt_r;
    slot_nxt    = slot_r;
    sending_nxt = sending_r;
    if (load) begin
      pre_cnt_nxt = '0;
      per_cnt_nxt = '0;
      slot_nxt    = '0;
      sending_nxt = 1'b1;
    end else if (tick && sending_r) begin
      if (pre_cnt_r >= prescale) begin
        pre_cnt_nxt = '0;
        if (per_cnt_r >= bit_period) begin
          per_cnt_nxt = '0;
          if (slot_inc >= SLOT_END) begin
            slot_nxt    = '0;
            sending_nxt = 1'b0;
          end else begin
            slot_nxt = slot_inc[SLOT_W-1:0];
          end
        end else begin
          per_cnt_nxt = per_cnt_r + 1'b1;
        end
      end else begin
        pre_cnt_nxt = pre_cnt_r + 1'b1;
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_cnt_r <= '0;
      per_cnt_r <= '0;
      slot_r    <= '0;
      sending_r <= 1'b0;
    end else begin
      pre_cnt_r <= pre_cnt_nxt;
      per_cnt_r <= per_cnt_nxt;
      slot_r    <= slot_nxt;
      sending_r <= sending_nxt;
    end
  end

  assign state_nxt = '{sending: sending_nxt, slot: slot_nxt, count: per_cnt_nxt};

endmodule

/* sv/dsft_lane.sv */
// one motor lane: frame register and pwm compare
module dsft_lane (
  input  logic                         clk,
  input  logic                         load,
  input  logic [dsft_pkg::VALUE_W-1:0] throttle,
  input  logic                         telem,
  input  logic [dsft_pkg::COUNT_W-1:0] one_high,
  input  logic [dsft_pkg::COUNT_W-1:0] zero_high,
  input  dsft_pkg::tb_state_t          state_nxt,
  output logic                         pin_nxt
);
  import dsft_pkg::*;

  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               data_slot;
  logic               frame_bit;
  logic [COUNT_W-1:0] compare;

  assign frame_nxt = load ? build_frame(throttle, telem) : frame_r;

  // frame held until the next load
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  // msb first: slot n sends bit 15-n
  assign data_slot = !state_nxt.slot[SLOT_W-1];
  assign frame_bit = frame_nxt[~state_nxt.slot[3:0]];
  assign compare   = frame_bit ? one_high : zero_high;
  assign pin_nxt   = state_nxt.sending && data_slot && (state_nxt.count < compare);

endmodule

/* sv/dshot_four_channel_transmitter.sv */
// top level of the four-channel dshot transmitter
//
// Input channel (in_valid/in_stall/in_data): each word is either a tick
// (req_type 0), one clock of the bit timebase, or a load (req_type 1) that
// latches four 11-bit motor values, builds their 16-bit frames and restarts
// transmission at slot 0. One word is taken per cycle when not stalled.
// Result channel (out_valid/out_stall/out_data): exactly one word per input
// word, in order, giving the four pin levels and busy_res after that word.
// Each result is registered in the output register. Throughput is one word
// per cycle while out_stall is low; a two-entry output buffer lets one more
// word enter while a result is stalled, after which in_stall rises until
// the receiver drains. Config port (cfg_valid/cfg_ready/cfg_index/cfg_data)
// is always ready; writes take effect on the next word. Unknown indexes are
// dropped. Reset (rst_n low, synchronous) restores register defaults, idles
// the line and empties the output buffer.
module dshot_four_channel_transmitter #(
  parameter int FRAME_SLOTS = 18
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dsft_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dsft_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsft_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsft_pkg::*;

  logic [7:0]         prescale_r;
  logic [COUNT_W-1:0] bit_period_r, one_high_r, zero_high_r;
  logic               telem_r;

  logic               in_fire, load, tick;
  tb_state_t          tb_nxt;
  logic [VALUE_W-1:0] motor_val [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] pins;
  out_word_t          res;

  out_word_t          out_r, skid_r;
  logic               out_valid_r, skid_valid_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r   <= PRESCALE_RST;
      bit_period_r <= BIT_PERIOD_RST;
      one_high_r   <= ONE_HIGH_RST;
      zero_high_r  <= ZERO_HIGH_RST;
      telem_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRESCALE:   prescale_r   <= cfg_data[7:0];
        CFG_BIT_PERIOD: bit_period_r <= cfg_data;
        CFG_ONE_HIGH:   one_high_r   <= cfg_data;
        CFG_ZERO_HIGH:  zero_high_r  <= cfg_data;
        CFG_TELEMETRY:  telem_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input decode
  assign in_fire = in_valid && !in_stall;
  assign load    = in_fire && in_data.req_type;
  assign tick    = in_fire && !in_data.req_type;

  assign motor_val[0] = in_data.motor_value_1;
  assign motor_val[1] = in_data.motor_value_2;
  assign motor_val[2] = in_data.motor_value_3;
  assign motor_val[3] = in_data.motor_value_4;

  dsft_timebase #(
    .FRAME_SLOTS(FRAME_SLOTS)
  ) u_timebase (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .tick      (tick),
    .prescale  (prescale_r),
    .bit_period(bit_period_r),
    .state_nxt (tb_nxt)
  );

  // one lane per motor
  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
    dsft_lane u_lane (
      .clk        (clk),
      .load       (load),
      .throttle   (motor_val[m]),
      .telem      (telem_r),
      .one_high   (one_high_r),
      .zero_high  (zero_high_r),
      .state_nxt  (tb_nxt),
      .pin_nxt    (pins[m])
    );
  end

  // merge lane pins with busy flag
  assign res = '{pin_1: pins[0], pin_2: pins[1], pin_3: pins[2], pin_4: pins[3],
                 busy_res: tb_nxt.sending};

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= res;
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/dsft_checker.sv */
// port-level checks for the dshot transmitter, bound to the top level
module dsft_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dsft_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input dsft_pkg::out_word_t out_data
);
  import dsft_pkg::*;

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without pending result");

  // no pin high outside a frame
  a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pin_1 || out_data.pin_2 || out_data.pin_3 || out_data.pin_4)
    |-> out_data.busy_res)
    else $error("pin high while idle");

  // a load shows busy in its result
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type && (!out_valid || !out_stall)
    |=> out_valid && out_data.busy_res)
    else $error("load result not busy");

endmodule

bind dshot_four_channel_transmitter dsft_checker u_dsft_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the four-channel dshot transmitter: random ticks and loads vs a line predictor
module tb;
  import dsft_pkg::*;

  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_LOAD     = 1'b1;
  localparam int   DATA_SLOTS   = 16;
  localparam int   FRAME_SLOTS  = 18;
  localparam int   MAX_GAP      = 8;
  localparam int   CHOKE_CYCLES = 60;
  localparam int   PHASE_WORDS  = 45;
  localparam int   PHASES       = 10;
  localparam int   CHOKE_PHASE  = 3;

  // predicts pin levels and busy for every accepted word, then checks results in order
  class dshot_line_scoreboard;
    logic [7:0]         prescale;
    logic [COUNT_W-1:0] bit_period;
    logic [COUNT_W-1:0] one_high;
    logic [COUNT_W-1:0] zero_high;
    logic               telemetry;
    logic [FRAME_W-1:0] lane_frame [MOTOR_COUNT];
    logic [7:0]         tick_count;
    logic [COUNT_W-1:0] count;
    int                 slot;
    bit                 sending;
    out_word_t          expected_lines [$];
    int                 fail_count;

    function new();
      prescale   = PRESCALE_RST;
      bit_period = BIT_PERIOD_RST;
      one_high   = ONE_HIGH_RST;
      zero_high  = ZERO_HIGH_RST;
      telemetry  = 1'b0;
      foreach (lane_frame[m]) lane_frame[m] = '0;
      tick_count = '0;
      count      = '0;
      slot       = 0;
      sending    = 1'b0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PRESCALE:   prescale   = val[7:0];
        CFG_BIT_PERIOD: bit_period = val;
        CFG_ONE_HIGH:   one_high   = val;
        CFG_ZERO_HIGH:  zero_high  = val;
        CFG_TELEMETRY:  telemetry  = val[0];
        default: ;
      endcase
    endfunction

    // 11-bit value, telemetry bit, then nibble parity of those 12 bits
    function logic [FRAME_W-1:0] encode(logic [VALUE_W-1:0] value);
      logic [11:0] body;
      logic [3:0]  parity;
      body   = {value, telemetry};
      parity = '0;
      for (int n = 0; n < 3; n++) parity ^= body[n*4 +: 4];
      return {body, parity};
    endfunction

    // pwm mode 1: high while the slot count is below the bit's high time
    function logic lane_level(int m);
      logic [COUNT_W-1:0] high_time;
      if (!sending || slot >= DATA_SLOTS) return 1'b0;
      high_time = lane_frame[m][FRAME_W-1-slot] ? one_high : zero_high;
      return count < high_time;
    endfunction

    function void note_word(in_word_t w);
      out_word_t line;
      if (w.req_type == REQ_LOAD) begin
        lane_frame[0] = encode(w.motor_value_1);
        lane_frame[1] = encode(w.motor_value_2);
        lane_frame[2] = encode(w.motor_value_3);
        lane_frame[3] = encode(w.motor_value_4);
        tick_count    = '0;
        count         = '0;
        slot          = 0;
        sending       = 1'b1;
      end else if (sending) begin
        // prescaler, then slot counter, then slot index
        if (tick_count >= prescale) begin
          tick_count = '0;
          if (count >= bit_period) begin
            count = '0;
            slot++;
            if (slot >= FRAME_SLOTS) begin
              slot    = 0;
              sending = 1'b0;
            end
          end else begin
            count++;
          end
        end else begin
          tick_count++;
        end
      end
      line.pin_1    = lane_level(0);
      line.pin_2    = lane_level(1);
      line.pin_3    = lane_level(2);
      line.pin_4    = lane_level(3);
      line.busy_res = sending;
      expected_lines.push_back(line);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (got !== want) begin
        $error("%s expected %b got %b", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_lines.size() == 0) begin
        $error("result word %b with nothing expected", got);
        fail_count++;
        return;
      end
      want = expected_lines.pop_front();
      compare_bit("pin_1", want.pin_1, got.pin_1);
      compare_bit("pin_2", want.pin_2, got.pin_2);
      compare_bit("pin_3", want.pin_3, got.pin_3);
      compare_bit("pin_4", want.pin_4, got.pin_4);
      compare_bit("busy_res", want.busy_res, got.busy_res);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dshot_line_scoreboard board = new();
  bit idle_in;
  bit idle_out;
  bit choke_req;

  dshot_four_channel_transmitter #(.FRAME_SLOTS(FRAME_SLOTS)) DUT (.*);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // values biased toward the field extremes
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t load_word(logic [VALUE_W-1:0] v1, logic [VALUE_W-1:0] v2,
                                         logic [VALUE_W-1:0] v3, logic [VALUE_W-1:0] v4);
    in_word_t w;
    w.req_type      = REQ_LOAD;
    w.motor_value_1 = v1;
    w.motor_value_2 = v2;
    w.motor_value_3 = v3;
    w.motor_value_4 = v4;
    return w;
  endfunction

  // tick words carry junk motor values that the block must ignore
  function automatic in_word_t tick_word();
    in_word_t w;
    w          = load_word(rand_value(), rand_value(), rand_value(), rand_value());
    w.req_type = REQ_TICK;
    return w;
  endfunction

  // offer one word, keep valid high until it is taken
  task automatic send_word(input in_word_t w);
    int gap;
    bit taken;
    gap = idle_in ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    board.note_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    board.write_reg(idx, val);
  endtask

  // drain, then rewrite every register plus one unmapped index
  task automatic apply_setting(input logic [7:0] ps, input logic [COUNT_W-1:0] bp,
                               input logic [COUNT_W-1:0] oh, input logic [COUNT_W-1:0] zh,
                               input logic tr);
    in_valid <= 1'b0;
    while (board.expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_PRESCALE, {8'($urandom), ps});
    write_reg(CFG_BIT_PERIOD, bp);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_TELEMETRY, {15'($urandom), tr});
    write_reg(CFG_IDX_W'(CFG_TELEMETRY + 1 + $urandom_range(0, 2)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // short slots: prescale 0 or 1 and a bit period of 0 to 2
  task automatic random_setting();
    logic [7:0]         ps;
    logic [COUNT_W-1:0] bp;
    logic [COUNT_W-1:0] oh;
    logic [COUNT_W-1:0] zh;
    ps = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
    bp = COUNT_W'($urandom_range(0, 2));
    oh = COUNT_W'($urandom_range(0, bp + 2));
    zh = COUNT_W'($urandom_range(0, bp + 2));
    if ($urandom_range(0, 5) == 0) oh = '1;
    if ($urandom_range(0, 5) == 0) zh = '0;
    apply_setting(ps, bp, oh, zh, 1'($urandom));
  endtask

  // mostly full frames started from idle, with occasional restarts mid-frame
  task automatic run_phase(input int words);
    for (int n = 0; n < words; n++) begin
      if ((!board.sending && $urandom_range(0, 3) == 0) || $urandom_range(0, 59) == 0)
        send_word(load_word(rand_value(), rand_value(), rand_value(), rand_value()));
      else
        send_word(tick_word());
    end
  endtask

  // result side: random stall per word, one long hold-off on request
  initial begin
    int        gap;
    bit        got;
    out_word_t word;
    out_stall <= 1'b0;
    forever begin
      gap = idle_out ? $urandom_range(0, MAX_GAP) : 0;
      if (choke_req) begin
        gap       = CHOKE_CYCLES;
        choke_req = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got  = out_valid;
        word = out_data;
        @(posedge clk);
      end while (!got);
      board.check_word(word);
    end
  end

  // stimulus
  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    idle_in   = 1'b0;
    idle_out  = 1'b0;
    choke_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle tick and a load under the reset timing
    send_word(tick_word());
    send_word(load_word('1, '0, 11'h555, 11'h2aa));
    send_word(tick_word());

    // registers changed mid-frame: one count per slot, ones held the whole slot, zeros low
    apply_setting(8'h00, 16'h0000, 16'hffff, 16'h0000, 1'b1);
    repeat (2) send_word(tick_word());
    send_word(load_word('0, '1, 11'h2aa, 11'h555));
    repeat (2) send_word(tick_word());
    // load during a frame, then run it out to idle
    send_word(load_word(11'h400, 11'h001, 11'h7fe, 11'h3ff));
    repeat (FRAME_SLOTS) send_word(tick_word());

    // random phases, the first two at the register extremes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       apply_setting(8'hff, 16'hffff, 16'hffff, 16'h0000, 1'b1);
        1:       apply_setting(8'h00, 16'h0000, 16'h0000, 16'hffff, 1'b0);
        default: random_setting();
      endcase
      idle_in  = 1'($urandom);
      idle_out = 1'($urandom);
      if (p == CHOKE_PHASE) begin
        idle_in   = 1'b0;
        choke_req = 1'b1;
      end
      run_phase(PHASE_WORDS);
    end

    in_valid <= 1'b0;
    while (board.expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.fail_count == 0)
      $display("dshot_four_channel_transmitter verification clean");
    else
      $display("dshot_four_channel_transmitter verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("dshot_four_channel_transmitter verification failed");
    $finish;
  end

endmodule
